### hdl/brs_pkg.sv
`default_nettype none

package brs_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LENGTH_W = 16;

    localparam logic [BYTE_W-1:0] CH_RPAREN    = 8'h29;
    localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_MAIN    = 3'd1,
        PH_SLASH   = 3'd2,
        PH_COMMENT = 3'd3,
        PH_STRING  = 3'd4,
        PH_ESCAPE  = 3'd5
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN    = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_ENDED    = 3'd3,
        ST_UNWANTED = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_IDLE     = 3'd6
    } status_t;

    // Control part of the scan state, carried between the state registers
    // and the step logic.
    typedef struct packed {
        phase_t phase;
        logic   anything;
    } ctrl_t;

    // Result of one byte step, minus the length.
    typedef struct packed {
        status_t status;
        logic    last;
        logic    zero_length;
    } result_t;

endpackage

`default_nettype wire

### hdl/brs_step.sv
`default_nettype none

module brs_step #(
    parameter int unsigned DEPTH_BITS  = 16,
    parameter int unsigned LENGTH_BITS = 16
) (
    input  brs_pkg::ctrl_t          ctrl,
    input  logic [DEPTH_BITS-1:0]   depth,
    input  logic [LENGTH_BITS-1:0]  count,
    input  logic [7:0]              byte_value,
    input  logic                    first,
    input  logic                    region_wanted,
    input  logic                    input_ended,
    output brs_pkg::ctrl_t          ctrl_next,
    output logic [DEPTH_BITS-1:0]   depth_next,
    output logic [LENGTH_BITS-1:0]  count_next,
    output brs_pkg::result_t        result
);
    import brs_pkg::*;

    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0]  DEPTH_ONE  = DEPTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 eff_phase;
    logic                   eff_any;
    logic [DEPTH_BITS-1:0]  eff_depth;
    logic [LENGTH_BITS-1:0] eff_count;
    logic [LENGTH_BITS-1:0] take_count;
    logic                   as_main;
    logic                   take;
    status_t                status;

    // a first beat restarts the scan
    always_comb
    begin
        if (first)
        begin
            eff_phase = PH_MAIN;
            eff_any   = 1'b0;
            eff_depth = DEPTH_ONE;
            eff_count = '0;
        end
        else
        begin
            eff_phase = ctrl.phase;
            eff_any   = ctrl.anything;
            eff_depth = depth;
            eff_count = count;
        end
    end

    assign take_count = (eff_count < LENGTH_MAX) ? eff_count + LENGTH_BITS'(1) : eff_count;

    always_comb
    begin
        as_main = 1'b0;
        case (eff_phase)
            PH_SLASH:   as_main = (byte_value != CH_SLASH);
            PH_COMMENT: as_main = (byte_value == CH_LF) || (byte_value == CH_CR);
            PH_STRING:  as_main = 1'b0;
            PH_ESCAPE:  as_main = 1'b0;
            default:    as_main = 1'b1;
        endcase
    end

    always_comb
    begin
        ctrl_next.phase    = eff_phase;
        ctrl_next.anything = eff_any;
        depth_next         = eff_depth;
        take               = 1'b0;
        status             = ST_TAKEN;

        if (first && !region_wanted)
        begin
            ctrl_next.phase = PH_IDLE;
            status          = ST_UNWANTED;
        end
        else if (!first && ctrl.phase == PH_IDLE)
        begin
            status = ST_IDLE;
        end
        else if (input_ended)
        begin
            ctrl_next.phase = PH_IDLE;
            status          = ST_ENDED;
        end
        else if (as_main)
        begin
            ctrl_next.phase = PH_MAIN;
            case (byte_value)
                CH_RPAREN:
                begin
                    if (eff_depth <= DEPTH_ONE)
                    begin
                        ctrl_next.phase = PH_IDLE;
                        status          = eff_any ? ST_ACCEPT : ST_EMPTY;
                    end
                    else
                    begin
                        depth_next = eff_depth - DEPTH_ONE;
                        take       = 1'b1;
                    end
                end
                CH_LPAREN:
                begin
                    if (eff_depth == DEPTH_MAX)
                    begin
                        ctrl_next.phase = PH_IDLE;
                        status          = ST_OVERFLOW;
                    end
                    else
                    begin
                        depth_next = eff_depth + DEPTH_ONE;
                        take       = 1'b1;
                    end
                end
                CH_QUOTE:
                begin
                    ctrl_next.phase = PH_STRING;
                    take            = 1'b1;
                end
                CH_SLASH:
                begin
                    ctrl_next.phase = PH_SLASH;
                    take            = 1'b1;
                end
                default:
                begin
                    take = 1'b1;
                end
            endcase
        end
        else
        begin
            take = 1'b1;
            case (eff_phase)
                PH_SLASH:   ctrl_next.phase = PH_COMMENT;
                PH_ESCAPE:  ctrl_next.phase = PH_STRING;
                PH_STRING:
                begin
                    if (byte_value == CH_BACKSLASH)
                        ctrl_next.phase = PH_ESCAPE;
                    else if (byte_value == CH_QUOTE)
                        ctrl_next.phase = PH_MAIN;
                end
                default:    ctrl_next.phase = eff_phase;
            endcase
        end

        if (take)
            ctrl_next.anything = 1'b1;
    end

    assign count_next         = take ? take_count : eff_count;
    assign result.status      = status;
    assign result.last        = (status != ST_TAKEN) && (status != ST_IDLE);
    assign result.zero_length = (status == ST_IDLE) || (status == ST_UNWANTED);

endmodule

`default_nettype wire

### hdl/balanced_region_scanner.sv
`default_nettype none

// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// item      | item_valid / item_stall    | byte_value, first, region_wanted, input_ended
// result    | result_valid / result_stall| status, region_length, last
//
// One beat in, one beat out. An item is first held in the input register;
// the step logic updates the scan state as it moves to the result register,
// so each item passes the input register and then the result register, and
// a new item is taken every cycle while the result side is not stalled.
// Throughput is set by the single state update per cycle.
// Reset (rst_n low) idles the scan and empties both registers.
// A stalled result holds the item in the input register; item_stall rises
// only while both registers are full and the result is stalled.
module balanced_region_scanner #(
    parameter int unsigned DEPTH_BITS  = 16,
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [7:0]                 byte_value,
    input  logic                       first,
    input  logic                       region_wanted,
    input  logic                       input_ended,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [brs_pkg::STATUS_W-1:0] status,
    output logic [brs_pkg::LENGTH_W-1:0] region_length,
    output logic                       last
);
    import brs_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       wanted_reg;
    logic       ended_reg;

    // scan state
    ctrl_t                  ctrl_reg;
    ctrl_t                  ctrl_next;
    logic [DEPTH_BITS-1:0]  depth_reg;
    logic [DEPTH_BITS-1:0]  depth_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    result_t                step_result;

    // result register
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [LENGTH_W-1:0]    length_reg;
    logic                   last_reg;

    logic advance;
    logic item_take;

    // move the held item on whenever the result slot is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    brs_step #(
        .DEPTH_BITS  (DEPTH_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .ctrl          (ctrl_reg),
        .depth         (depth_reg),
        .count         (count_reg),
        .byte_value    (byte_reg),
        .first         (first_reg),
        .region_wanted (wanted_reg),
        .input_ended   (ended_reg),
        .ctrl_next     (ctrl_next),
        .depth_next    (depth_next),
        .count_next    (count_next),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            byte_reg   <= byte_value;
            first_reg  <= first;
            wanted_reg <= region_wanted;
            ended_reg  <= input_ended;
        end
    end

    // scan state advances once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase    <= PH_IDLE;
            ctrl_reg.anything <= 1'b0;
            depth_reg         <= '0;
            count_reg         <= '0;
        end
        else if (advance)
        begin
            ctrl_reg  <= ctrl_next;
            depth_reg <= depth_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // length zero-extends or truncates to the 16-bit result field
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= step_result.status;
            last_reg   <= step_result.last;
            length_reg <= step_result.zero_length ? '0 : LENGTH_W'(count_next);
        end
    end

    assign result_valid  = out_valid_reg;
    assign status        = status_reg;
    assign region_length = length_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

### hdl/brs_checker.sv
`default_nettype none

module brs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_stall,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [brs_pkg::STATUS_W-1:0]  status,
    input  logic [brs_pkg::LENGTH_W-1:0]  region_length,
    input  logic                          last
);
    import brs_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(status) && $stable(region_length) && $stable(last))
        else $error("stalled result beat changed");

    // back pressure only comes from a stalled, full result side
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled while result side can drain");

    a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            last == ((status != ST_TAKEN) && (status != ST_IDLE)))
        else $error("last does not match status");

    a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((status == ST_IDLE) || (status == ST_UNWANTED)) |->
            region_length == '0)
        else $error("idle or unwanted result carries a length");

endmodule

bind balanced_region_scanner brs_checker u_brs_checker (.*);

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;

    import brs_pkg::*;

    localparam int unsigned DEPTH_BITS  = 16;
    localparam int unsigned LENGTH_BITS = 16;

    // Longest stretch with no beat on either channel before the run is
    // declared hung; it exceeds the longest deliberate hold-off, HOLD_CYCLES.
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned NEST_LEVELS  = 100;

    typedef struct packed {
        status_t             status;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } scan_outcome_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                item_valid    = 1'b0;
    logic                item_stall;
    logic [7:0]          byte_value    = 8'h00;
    logic                first         = 1'b0;
    logic                region_wanted = 1'b0;
    logic                input_ended   = 1'b0;
    logic                result_valid;
    logic                result_stall  = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [LENGTH_W-1:0] region_length;
    logic                last;

    // Tracked scan state, updated once per accepted item beat.
    phase_t                 track_phase    = PH_IDLE;
    logic [DEPTH_BITS-1:0]  track_depth    = '0;
    logic                   track_anything = 1'b0;
    logic [LENGTH_BITS-1:0] track_count    = '0;

    // Outcomes predicted for accepted items, oldest first.
    scan_outcome_t pending_outcomes[$];
    scan_outcome_t due;
    int unsigned   failures      = 0;
    int unsigned   results_seen  = 0;

    // Pacing knobs, changed by the tests between phases.
    int unsigned gap_max       = 0;
    int unsigned burst_max     = 1;
    int unsigned burst_left    = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_request  = 0;

    balanced_region_scanner #(
        .DEPTH_BITS (DEPTH_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .byte_value   (byte_value),
        .first        (first),
        .region_wanted(region_wanted),
        .input_ended  (input_ended),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .region_length(region_length),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scan tracking
    // ------------------------------------------------------------------

    // Consume one byte: bump the saturating length and mark the region
    // as non-empty.
    function automatic status_t count_byte();
        if (track_count != '1)
            track_count++;
        track_anything = 1'b1;
        return ST_TAKEN;
    endfunction

    // Byte seen in main text: parentheses move the depth, a quote opens a
    // string, a slash may open a comment. The closing paren of depth 1 and
    // an opening paren at full depth end the scan without being consumed.
    function automatic status_t main_text_byte(input logic [7:0] b);
        status_t st;
        st = ST_TAKEN;
        if (b == CH_RPAREN && track_depth <= 1)
        begin
            track_phase = PH_IDLE;
            if (track_anything)
                st = ST_ACCEPT;
            else
                st = ST_EMPTY;
        end
        else if (b == CH_LPAREN && track_depth == '1)
        begin
            track_phase = PH_IDLE;
            st = ST_OVERFLOW;
        end
        else
        begin
            if (b == CH_RPAREN)
                track_depth--;
            else if (b == CH_LPAREN)
                track_depth++;
            else if (b == CH_QUOTE)
                track_phase = PH_STRING;
            else if (b == CH_SLASH)
                track_phase = PH_SLASH;
            st = count_byte();
        end
        return st;
    endfunction

    // Dispatch a byte on the current lexical phase.
    function automatic status_t text_byte(input logic [7:0] b);
        status_t st;
        case (track_phase)
            PH_SLASH:
            begin
                if (b == CH_SLASH)
                begin
                    track_phase = PH_COMMENT;
                    st = count_byte();
                end
                else
                begin
                    // Lone slash: the byte after it is plain main text.
                    track_phase = PH_MAIN;
                    st = main_text_byte(b);
                end
            end
            PH_COMMENT:
            begin
                // A line ending closes the comment and counts as main text.
                if (b == CH_LF || b == CH_CR)
                begin
                    track_phase = PH_MAIN;
                    st = main_text_byte(b);
                end
                else
                    st = count_byte();
            end
            PH_STRING:
            begin
                if (b == CH_BACKSLASH)
                    track_phase = PH_ESCAPE;
                else if (b == CH_QUOTE)
                    track_phase = PH_MAIN;
                st = count_byte();
            end
            PH_ESCAPE:
            begin
                track_phase = PH_STRING;
                st = count_byte();
            end
            default:
            begin
                track_phase = PH_MAIN;
                st = main_text_byte(b);
            end
        endcase
        return st;
    endfunction

    // Outcome of one accepted item beat.
    function automatic scan_outcome_t scan_step_outcome(input logic [7:0] b, input logic f,
                                                        input logic w, input logic e);
        scan_outcome_t o;
        status_t       st;
        o.status = ST_IDLE;
        o.length = '0;
        o.last   = 1'b0;
        if (f)
        begin
            // A first beat always restarts, dropping any scan in progress.
            track_depth    = DEPTH_BITS'(1);
            track_anything = 1'b0;
            track_count    = '0;
            if (!w)
            begin
                track_phase = PH_IDLE;
                o.status    = ST_UNWANTED;
                o.last      = 1'b1;
                return o;
            end
            track_phase = PH_MAIN;
        end
        else if (track_phase == PH_IDLE)
            return o;

        if (e)
        begin
            // End of text rejects the scan in every phase.
            track_phase = PH_IDLE;
            st = ST_ENDED;
        end
        else
            st = text_byte(b);
        o.status = st;
        o.length = LENGTH_W'(track_count);
        o.last   = (st != ST_TAKEN);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    // Offer one item beat and hold it until accepted. Bursts of random
    // length are separated by random gaps with valid low.
    task automatic send_item(input logic [7:0] b, input logic f, input logic w, input logic e);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        item_valid    <= 1'b1;
        byte_value    <= b;
        first         <= f;
        region_wanted <= w;
        input_ended   <= e;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_outcomes.push_back(scan_step_outcome(b, f, w, e));
    endtask

    // Send a string as one wanted scan; the first character carries first.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == 0, 1'b1, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall in runs of random length; a hold request overrides the pattern
    // with one long stall counted here.
    initial
    begin : stall_pattern
        int unsigned run_left;
        int unsigned hold_left;
        bit          stall_now;
        run_left  = 0;
        hold_left = 0;
        stall_now = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stall_now = ($urandom_range(1, 100) <= stall_pct);
                    run_left  = $urandom_range(1, 8);
                end
                run_left--;
                result_stall <= stall_now;
            end
        end
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_outcomes.size() == 0)
                note_failure($sformatf(
                    "result %0d arrived with none due: status %0d len %0d last %0b",
                    results_seen, status, region_length, last));
            else
            begin
                due = pending_outcomes.pop_front();
                if (status !== due.status || region_length !== due.length || last !== due.last)
                    note_failure($sformatf(
                        {"result %0d: expected status %0d len %0d last %0b, ",
                         "got status %0d len %0d last %0b"},
                        results_seen, due.status, due.length, due.last,
                        status, region_length, last));
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("balanced_region_scanner: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-written scans: idle and unwanted beats, empty region,
    // end of text on the first beat, strings with escapes, comments closed
    // by CR and LF, a lone slash, a restart, and byte extremes.
    task automatic test_directed_cases();
        gap_max   = 2;
        burst_max = 4;
        stall_pct = 20;
        send_item(8'h00, 1'b0, 1'b0, 1'b0);        // idle, no scan running
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);        // region not wanted
        send_item(CH_RPAREN, 1'b1, 1'b1, 1'b0);    // empty region
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);        // text ends on the first beat
        send_text("a\"\\\")\"/x//)\r)");           // string, escape, slash, comment
        send_text("//\n)");                        // LF closes the comment
        send_item(CH_LPAREN, 1'b1, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);        // restart mid scan
        send_item(CH_LF, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1, 1'b1);        // text ends inside
    endtask

    // One long scan: nest deep, take a plain byte, then close every level
    // and accept. Run at full rate to keep it short.
    task automatic test_deep_nesting();
        gap_max   = 0;
        burst_max = 1;
        stall_pct = 0;
        send_item(CH_LPAREN, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < NEST_LEVELS; i++)
            send_item(CH_LPAREN, 1'b0, 1'b0, 1'b0);
        send_item("x", 1'b0, 1'b0, 1'b0);
        // Close all opened levels, then the closing paren of depth 1.
        for (int i = 0; i < NEST_LEVELS + 2; i++)
            send_item(CH_RPAREN, 1'b0, 1'b0, 1'b0);
    endtask

    // Mostly well-formed scans with random content weighted toward the
    // characters that move the lexer, plus restarts, early ends, unwanted
    // regions and idle noise.
    task automatic run_scan_mix(input int unsigned count);
        int unsigned done;
        int unsigned r;
        logic [7:0]  b;
        logic        f;
        logic        w;
        logic        e;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                b = CH_LPAREN;
            else if (r < 30)
                b = CH_RPAREN;
            else if (r < 38)
                b = CH_QUOTE;
            else if (r < 44)
                b = CH_BACKSLASH;
            else if (r < 54)
                b = CH_SLASH;
            else if (r < 60)
                b = CH_LF;
            else if (r < 64)
                b = CH_CR;
            else
                b = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            w = 1'($urandom_range(0, 1));
            if (track_phase == PH_IDLE)
            begin
                f = (r >= 8);
                if (f)
                    w = (r >= 14);
                e = ($urandom_range(0, 39) == 0) || (!f && $urandom_range(0, 1) == 1);
            end
            else
            begin
                f = (r < 2);
                if (f)
                    w = ($urandom_range(0, 9) != 0);
                e = (r >= 2 && r < 5);
            end
            // Idle beats are ignored by the block; do not count them.
            if (f || track_phase != PH_IDLE)
                done++;
            send_item(b, f, w, e);
        end
    endtask

    task automatic test_random_scans();
        // Full rate, no stalls.
        gap_max   = 0;
        burst_max = 1;
        stall_pct = 0;
        run_scan_mix(300);
        // Moderate gaps and stalls.
        gap_max   = 6;
        burst_max = 8;
        stall_pct = 40;
        run_scan_mix(500);
        // Sparse input, heavy stalls.
        gap_max   = 16;
        burst_max = 3;
        stall_pct = 70;
        run_scan_mix(400);
    endtask

    // Hold off the result side for a long stretch while items keep coming,
    // so both registers fill and the block stalls its input.
    task automatic test_backpressure();
        gap_max      = 0;
        burst_max    = 1;
        stall_pct    = 0;
        hold_request = HOLD_CYCLES;
        send_item(CH_LPAREN, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < 40; i++)
            send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0, 1'b0, 1'b0);
        send_item(CH_RPAREN, 1'b0, 1'b0, 1'b0);
        send_item(CH_RPAREN, 1'b0, 1'b0, 1'b0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_deep_nesting();
        test_random_scans();
        test_backpressure();
        item_valid <= 1'b0;
        stall_pct = 0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        // Let any stray result show before judging.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_outcomes.size() == 0)
            $display("balanced_region_scanner: match");
        else
            $display("balanced_region_scanner: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/brs_pkg.sv
hdl/brs_step.sv
hdl/balanced_region_scanner.sv
hdl/brs_checker.sv
sim/testbench.sv
